FILE: rtl/core/tptg_pkg.sv
// Package for the three-channel pulse tone generator.
// Holds sizing constants, the request codes and the timbre width lookup.
// No dependencies; every other file of the block imports it.
package tptg_pkg;

  localparam int unsigned CHANNELS     = 3;
  localparam int unsigned PERIOD_WIDTH = 15;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned TIMBRE_W = 3;
  localparam int unsigned OUT_W    = 3;
  localparam int unsigned WIDTH_W  = 4;

  localparam int unsigned CLOCK_HZ  = 1000000;
  localparam int unsigned FREQ_MIN  = 31;
  localparam int unsigned FREQ_MAX  = 10000;
  localparam int unsigned TOP_LIMIT = 32767;
  localparam int unsigned TOP_MIN   = 2;
  localparam int unsigned FIELD_MAX = (1 << PERIOD_WIDTH) - 1;
  localparam int unsigned PERIOD_MAX = (FIELD_MAX < TOP_LIMIT) ? FIELD_MAX : TOP_LIMIT;

  // Dividend is CLOCK_HZ + f/2, divisor the clamped frequency.
  localparam int unsigned DIVD_W = $clog2(CLOCK_HZ + FREQ_MAX / 2 + 1);
  localparam int unsigned DIVS_W = $clog2(FREQ_MAX + 1);
  localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

  // Channels that show up in the result fields.
  localparam int unsigned LANES = (CHANNELS < OUT_W) ? CHANNELS : OUT_W;

  typedef logic [PERIOD_WIDTH-1:0] period_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 2'd0,
    REQ_START    = 2'd1,
    REQ_STOP     = 2'd2,
    REQ_STOP_ALL = 2'd3
  } req_e;

  typedef enum logic [TIMBRE_W-1:0] {
    TIMBRE_HALF    = 3'd0,
    TIMBRE_3_8     = 3'd1,
    TIMBRE_QUARTER = 3'd2,
    TIMBRE_EIGHTH  = 3'd3,
    TIMBRE_16TH    = 3'd4
  } timbre_e;

  // Pulse width in sixteenths of the period; unlisted codes give 50%.
  function automatic logic [WIDTH_W-1:0] width_lookup(input logic [TIMBRE_W-1:0] code);
    logic [WIDTH_W-1:0] w;
    unique case (code)
      TIMBRE_HALF:    w = WIDTH_W'(8);
      TIMBRE_3_8:     w = WIDTH_W'(6);
      TIMBRE_QUARTER: w = WIDTH_W'(4);
      TIMBRE_EIGHTH:  w = WIDTH_W'(2);
      TIMBRE_16TH:    w = WIDTH_W'(1);
      default:        w = WIDTH_W'(8);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/tptg_req_if.sv
// Request channel of the pulse tone generator: valid/ready plus request payload.
// Depends on tptg_pkg for field widths.
interface tptg_req_if;
  import tptg_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CH_W-1:0]   channel;
  logic [FREQ_W-1:0] tone_frequency;

  modport source (output valid, output req_type, output channel, output tone_frequency,
                  input ready);
  modport sink   (input valid, input req_type, input channel, input tone_frequency,
                  output ready);
endinterface

FILE: rtl/core/tptg_res_if.sv
// Result channel of the pulse tone generator: valid/ready plus level and active bits.
// Depends on tptg_pkg for field widths.
interface tptg_res_if;
  import tptg_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] tone_levels;
  logic [OUT_W-1:0] active_mask;

  modport source (output valid, output tone_levels, output active_mask, input ready);
  modport sink   (input valid, input tone_levels, input active_mask, output ready);
endinterface

FILE: rtl/core/three_channel_pulse_tone_generator.sv
// Three-channel pulse tone generator: per-channel period/compare counters on 1 MHz ticks.
// Sequence: tick, stop and out-of-range start items go from acceptance through ST_RESP to the result; a start
//   item goes through ST_DIV (bit-serial period divide, one quotient bit per cycle), ST_LOAD and ST_RESP.
// Requests are taken one at a time: ready is low until the current item has posted its result,
//   and ST_RESP waits while the previous result is still held and not taken.
// Reset (rst_ni low, asynchronous): all channels stopped, timbre code 0, no result pending.
module three_channel_pulse_tone_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tptg_req_if.sink                      req_i,
  tptg_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [tptg_pkg::TIMBRE_W-1:0] cfg_wdata_i
);
  import tptg_pkg::*;

  // Control sequence: accept, optional divide and load, then post the result.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_RESP
  } state_e;

  state_e state_q;

  logic [TIMBRE_W-1:0] timbre_q;
  logic [CH_W-1:0]     ch_q;

  // Channel state, one lane per channel.
  logic    [CHANNELS-1:0] active_q;
  period_t                cnt_q [CHANNELS];
  period_t                per_q [CHANNELS];
  period_t                cmp_q [CHANNELS];

  // Restoring divider: remainder, dividend shifting out while quotient shifts in.
  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] div_q;
  logic [STEP_W-1:0] step_q;

  // Result register; it parts the output side from the request side.
  logic             res_valid_q;
  logic [OUT_W-1:0] levels_q;
  logic [OUT_W-1:0] mask_q;

  logic accept;
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign res_o.valid       = res_valid_q;
  assign res_o.tone_levels = levels_q;
  assign res_o.active_mask = mask_q;

  // Clamp the requested frequency and form the rounded dividend.
  logic [DIVS_W-1:0] freq_clamped;
  logic [DIVD_W-1:0] dividend;
  logic              ch_in_range;

  always_comb begin
    if (req_i.tone_frequency < FREQ_W'(FREQ_MIN)) begin
      freq_clamped = DIVS_W'(FREQ_MIN);
    end else if (req_i.tone_frequency > FREQ_W'(FREQ_MAX)) begin
      freq_clamped = DIVS_W'(FREQ_MAX);
    end else begin
      freq_clamped = req_i.tone_frequency[DIVS_W-1:0];
    end
    dividend    = DIVD_W'(CLOCK_HZ) + DIVD_W'(freq_clamped >> 1);
    ch_in_range = (32'(req_i.channel) < CHANNELS);
  end

  // One quotient bit per cycle.
  logic [DIVS_W:0]   trial;
  logic              trial_ge;
  logic [DIVS_W-1:0] rem_d;
  logic [DIVD_W-1:0] quo_d;

  always_comb begin
    trial    = {rem_q, quo_q[DIVD_W-1]};
    trial_ge = (trial >= {1'b0, div_q});
    rem_d    = trial_ge ? DIVS_W'(trial - {1'b0, div_q}) : DIVS_W'(trial);
    quo_d    = {quo_q[DIVD_W-2:0], trial_ge};
  end

  // Clamp the period, then scale it by the pulse width and round to sixteenths.
  period_t                top_val;
  logic [WIDTH_W-1:0]     width_val;
  logic [PERIOD_WIDTH+3:0] prod;
  period_t                cmp_raw;
  period_t                cmp_val;

  always_comb begin
    if (quo_q < DIVD_W'(TOP_MIN)) begin
      top_val = PERIOD_WIDTH'(TOP_MIN);
    end else if (quo_q > DIVD_W'(PERIOD_MAX)) begin
      top_val = PERIOD_WIDTH'(PERIOD_MAX);
    end else begin
      top_val = quo_q[PERIOD_WIDTH-1:0];
    end
    width_val = width_lookup(timbre_q);
    prod      = (PERIOD_WIDTH+4)'(top_val) * (PERIOD_WIDTH+4)'(width_val)
              + (PERIOD_WIDTH+4)'(8);
    cmp_raw   = prod[PERIOD_WIDTH+3:4];
    if (cmp_raw == '0) begin
      cmp_val = PERIOD_WIDTH'(1);
    end else if (cmp_raw >= top_val) begin
      cmp_val = top_val - PERIOD_WIDTH'(1);
    end else begin
      cmp_val = cmp_raw;
    end
  end

  // Levels and active bits from the current channel state.
  logic [OUT_W-1:0] levels_now;
  logic [OUT_W-1:0] mask_now;

  always_comb begin
    levels_now = '0;
    mask_now   = '0;
    for (int c = 0; c < LANES; c++) begin
      mask_now[c]   = active_q[c];
      levels_now[c] = active_q[c] && (cnt_q[c] < cmp_q[c]);
    end
  end

  // Next counter value on a tick: advance, wrap at the period.
  period_t cnt_next [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if ((PERIOD_WIDTH+1)'(cnt_q[c]) + (PERIOD_WIDTH+1)'(1) >= (PERIOD_WIDTH+1)'(per_q[c])) begin
        cnt_next[c] = '0;
      end else begin
        cnt_next[c] = cnt_q[c] + PERIOD_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timbre_q    <= '0;
      ch_q        <= '0;
      active_q    <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      levels_q    <= '0;
      mask_q      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
        per_q[c] <= '0;
        cmp_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        timbre_q <= cfg_wdata_i;
      end

      // Drop the result once taken, unless a new one is posted below.
      if (res_valid_q && res_o.ready && (state_q != ST_RESP)) begin
        res_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ch_q    <= req_i.channel;
            // Only an in-range start goes through the divider.
            state_q <= ((req_e'(req_i.req_type) == REQ_START) && ch_in_range) ?
                       ST_DIV : ST_RESP;
            unique case (req_e'(req_i.req_type))
              REQ_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (active_q[c]) begin
                    cnt_q[c] <= cnt_next[c];
                  end
                end
              end
              REQ_START: begin
                // Out-of-range channel: no divide, just report.
                if (ch_in_range) begin
                  rem_q   <= '0;
                  quo_q   <= dividend;
                  div_q   <= freq_clamped;
                  step_q  <= '0;
                end
              end
              REQ_STOP: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (req_i.channel == CH_W'(c)) begin
                    active_q[c] <= 1'b0;
                    cnt_q[c]    <= '0;
                    per_q[c]    <= '0;
                    cmp_q[c]    <= '0;
                  end
                end
              end
              REQ_STOP_ALL: begin
                active_q <= '0;
                for (int c = 0; c < CHANNELS; c++) begin
                  cnt_q[c] <= '0;
                  per_q[c] <= '0;
                  cmp_q[c] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIVD_W - 1)) begin
            state_q <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          // Restart the addressed channel with the new period and compare.
          for (int c = 0; c < CHANNELS; c++) begin
            if (ch_q == CH_W'(c)) begin
              active_q[c] <= 1'b1;
              cnt_q[c]    <= '0;
              per_q[c]    <= top_val;
              cmp_q[c]    <= cmp_val;
            end
          end
          state_q <= ST_RESP;
        end

        ST_RESP: begin
          // Hold until the result register is free or draining.
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            levels_q    <= levels_now;
            mask_q      <= mask_now;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Every playing channel keeps a sane period, compare and counter.
  logic [CHANNELS-1:0] chan_ok;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_ok[c] = !active_q[c] ||
                   ((per_q[c] >= PERIOD_WIDTH'(TOP_MIN)) && (cmp_q[c] != '0) &&
                    (cmp_q[c] < per_q[c]) && (cnt_q[c] < per_q[c]));
    end
  end

  a_chan_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &chan_ok)
    else $error("playing channel with inconsistent period, compare or counter");

  a_level_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((levels_q & ~mask_q) == '0))
    else $error("level high on a channel that is not playing");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while previous item still in work");

  a_div_ends_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == STEP_W'(DIVD_W - 1)) |=> (state_q == ST_LOAD))
    else $error("divider did not hand over to load after its last step");

endmodule
